// ===== rtl/pcm_voice_mixer_macros.svh =====
// Assertion macros for the voice mixer RTL.
// Depends on nothing; included by files that check their own logic.
`ifndef PCM_VOICE_MIXER_MACROS_SVH
`define PCM_VOICE_MIXER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PVM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pvm_pkg.sv =====
// Shared types and constants of the voice mixer.
// Depends on nothing; imported by the mixer top level.
package pvm_pkg;

    localparam int MIX_W    = 16;
    localparam int SMP_W    = 8;
    localparam int ADDR_W   = 16;
    localparam int LEN_W    = 16;
    localparam int CLIPIX_W = 4;
    localparam int CNT_W    = 5;
    localparam int ACTV_W   = 3;

    localparam logic signed [MIX_W-1:0] MIX_MAX = 16'sh7FFF;
    localparam logic signed [MIX_W-1:0] MIX_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_PLAY      = 2'd1,
        OP_WR_SAMPLE = 2'd2,
        OP_WR_CLIP   = 2'd3
    } t_pvm_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_TICK_RD,
        ST_TICK_ACC,
        ST_PLAY_SCAN,
        ST_PLAY_LOAD,
        ST_FINISH
    } t_pvm_state;

    typedef struct packed {
        t_pvm_op                   operation;
        logic [CLIPIX_W-1:0]       clip_index;
        logic [ADDR_W-1:0]         address;
        logic signed [SMP_W-1:0]   sample_value;
        logic [LEN_W-1:0]          clip_length;
        logic                      solo_flag;
    } t_pvm_in;

    typedef struct packed {
        logic signed [MIX_W-1:0]   mixed_sample;
        logic                      sample_valid;
        logic                      request_accepted;
        logic [ACTV_W-1:0]         active_voices;
    } t_pvm_out;

endpackage

// ===== rtl/pcm_voice_mixer.sv =====
// Top level of the multi-voice PCM sample player and mixer.
// Depends on pvm_pkg, pvm_ram and pcm_voice_mixer_macros.svh.
//
// Multi-voice sample player. Each input transaction is one command: a tick
// (mix one output sample), a play request for a clip, a write into the
// sample memory, or a write of a clip descriptor (start, length, solo).
// Every command returns exactly one result transaction carrying the
// saturated 16-bit mix (ticks only, zero otherwise), a tick flag, the play
// acceptance flag and the number of voices still playing. The block works
// on one command at a time under a small sequencer; o_in_stall is high from
// acceptance until the result has been handed to the output register.
// A tick reads and then accumulates each voice in turn (a read and an
// accumulate state per voice, set by the registered read of the sample
// memory and the single shared accumulator); a non-solo play request that
// passes its checks scans the voices, one voice compared per cycle, for a
// free or the shortest voice, then loads it; every other command goes from
// dispatch straight to finish. The result register loads as the sequencer
// returns to idle, where the next command can be taken. The output
// register lets the next command be accepted while a result still waits
// on i_out_stall; a command whose result is ready while the previous one
// still waits holds in its last state until the output register frees.
// The user must write clip_count through i_cfg_we/i_cfg_wdata only while
// the block is idle; the block itself does not enforce this. The sample
// memory has no reset: play only samples that were written. SAMPLE_WORDS
// must be a power of two; sample addresses wrap modulo SAMPLE_WORDS.
`include "pcm_voice_mixer_macros.svh"

module pcm_voice_mixer #(
    parameter int VOICES       = 4,
    parameter int CLIPS        = 16,
    parameter int SAMPLE_WORDS = 65536
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  pvm_pkg::t_pvm_in              i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output pvm_pkg::t_pvm_out             o_out_data,
    input  logic                          i_cfg_we,
    input  logic [pvm_pkg::CNT_W-1:0]     i_cfg_wdata
);
    import pvm_pkg::*;

    // Widths that follow from the parameters
    localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW     = (CLIPS > 1) ? $clog2(CLIPS) : 1;
    localparam int AW     = $clog2(SAMPLE_WORDS);
    localparam int ACC_W  = MIX_W + $clog2(VOICES) + 1;
    localparam int VCNT_W = $clog2(VOICES + 1);
    localparam logic [VW-1:0] LAST_V = VW'(VOICES - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(MIX_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(MIX_MIN);

    // Sequencer and command
    t_pvm_state r_state, n_state;
    t_pvm_in    r_item;
    logic [VW-1:0] r_v, n_v;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic r_accepted, n_accepted;

    // Voice state
    logic [VOICES-1:0] r_busy, n_busy;
    logic [VOICES-1:0] r_is_solo, n_is_solo;
    logic [ADDR_W-1:0] r_vaddr [VOICES];
    logic [ADDR_W-1:0] n_vaddr [VOICES];
    logic [LEN_W-1:0]  r_vrem  [VOICES];
    logic [LEN_W-1:0]  n_vrem  [VOICES];
    logic r_lock, n_lock;

    // Slot search
    logic r_free_found, n_free_found;
    logic [VW-1:0] r_free_slot, n_free_slot;
    logic [VW-1:0] r_min_slot, n_min_slot;
    logic [LEN_W:0] r_least, n_least;

    // Clip descriptors and configuration
    logic [ADDR_W-1:0] r_clip_start [CLIPS];
    logic [ADDR_W-1:0] n_clip_start [CLIPS];
    logic [LEN_W-1:0]  r_clip_len   [CLIPS];
    logic [LEN_W-1:0]  n_clip_len   [CLIPS];
    logic [CLIPS-1:0]  r_clip_solo, n_clip_solo;
    logic [CNT_W-1:0]  r_clip_count;

    // Output register
    logic      r_out_valid, n_out_valid;
    t_pvm_out  r_out_data, n_out_data;

    // Sample memory port
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [SMP_W-1:0] ram_rdata;

    // Helpers
    logic [CW-1:0]  k_idx;
    logic           k_in_table;
    logic           k_lt_count;
    logic           play_ok;
    logic           in_accept;
    logic           out_free;
    logic           last_v;
    logic [VW-1:0]  load_slot;
    logic signed [ACC_W-1:0] smp_term;
    logic signed [MIX_W-1:0] mix_sat;
    logic [VCNT_W-1:0] vcount;
    logic [VOICES-1:0] rem_live;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign last_v     = (r_v == LAST_V);

    // Clip lookup for the command held in r_item
    assign k_idx      = CW'(r_item.clip_index);
    assign k_in_table = (int'(r_item.clip_index) < CLIPS);
    assign k_lt_count = ({1'b0, r_item.clip_index} < r_clip_count);
    assign play_ok    = k_in_table && k_lt_count && (r_clip_len[k_idx] != '0);
    assign load_slot  = r_free_found ? r_free_slot : r_min_slot;

    // Current voice sample, scaled by 256 and sign extended
    assign ram_raddr = AW'(r_vaddr[r_v]);
    assign smp_term  = ACC_W'(signed'({ram_rdata, 8'd0}));

    // Saturate the mix to 16 bits
    always_comb begin
        if (r_acc > SAT_HI) begin
            mix_sat = MIX_MAX;
        end else if (r_acc < SAT_LO) begin
            mix_sat = MIX_MIN;
        end else begin
            mix_sat = r_acc[MIX_W-1:0];
        end
    end

    // Count busy voices; flag voices with samples left
    always_comb begin
        vcount = '0;
        for (int i = 0; i < VOICES; i++) begin
            vcount   = vcount + VCNT_W'(r_busy[i]);
            rem_live[i] = (r_vrem[i] != '0);
        end
    end

    pvm_ram #(
        .WIDTH (SMP_W),
        .DEPTH (SAMPLE_WORDS)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(r_item.address)),
        .i_wdata (r_item.sample_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (r_item.operation)
                    OP_TICK: n_state = ST_TICK_RD;
                    OP_PLAY: begin
                        if (play_ok && !r_clip_solo[k_idx] && !r_lock) begin
                            n_state = ST_PLAY_SCAN;
                        end else begin
                            n_state = ST_FINISH;
                        end
                    end
                    default: n_state = ST_FINISH;
                endcase
            end
            ST_TICK_RD:   n_state = ST_TICK_ACC;
            ST_TICK_ACC:  n_state = last_v ? ST_FINISH : ST_TICK_RD;
            ST_PLAY_SCAN: n_state = last_v ? ST_PLAY_LOAD : ST_PLAY_SCAN;
            ST_PLAY_LOAD: n_state = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath control
    always_comb begin
        n_v          = r_v;
        n_acc        = r_acc;
        n_accepted   = r_accepted;
        n_busy       = r_busy;
        n_is_solo    = r_is_solo;
        n_vaddr      = r_vaddr;
        n_vrem       = r_vrem;
        n_lock       = r_lock;
        n_free_found = r_free_found;
        n_free_slot  = r_free_slot;
        n_min_slot   = r_min_slot;
        n_least      = r_least;
        n_clip_start = r_clip_start;
        n_clip_len   = r_clip_len;
        n_clip_solo  = r_clip_solo;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        ram_we       = 1'b0;

        // Drop the result once the consumer takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
            end
            ST_DISPATCH: begin
                n_acc        = '0;
                n_accepted   = 1'b0;
                n_v          = '0;
                n_free_found = 1'b0;
                n_free_slot  = '0;
                n_min_slot   = '0;
                n_least      = '1;
                unique case (r_item.operation)
                    OP_TICK: begin
                    end
                    OP_PLAY: begin
                        // Solo clip: silence everything and restart on voice 0
                        if (play_ok && r_clip_solo[k_idx]) begin
                            n_busy       = '0;
                            n_is_solo    = '0;
                            n_busy[0]    = 1'b1;
                            n_is_solo[0] = 1'b1;
                            n_vaddr[0]   = r_clip_start[k_idx];
                            n_vrem[0]    = r_clip_len[k_idx];
                            n_lock       = 1'b1;
                            n_accepted   = 1'b1;
                        end
                    end
                    OP_WR_SAMPLE: begin
                        ram_we = 1'b1;
                    end
                    OP_WR_CLIP: begin
                        if (k_in_table) begin
                            n_clip_start[k_idx] = r_item.address;
                            n_clip_len[k_idx]   = r_item.clip_length;
                            n_clip_solo[k_idx]  = r_item.solo_flag;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_TICK_RD: begin
            end
            ST_TICK_ACC: begin
                // Mix the sample read last cycle and advance this voice
                if (r_busy[r_v]) begin
                    n_acc        = r_acc + smp_term;
                    n_vaddr[r_v] = r_vaddr[r_v] + 1'b1;
                    n_vrem[r_v]  = r_vrem[r_v] - 1'b1;
                    if (r_vrem[r_v] == LEN_W'(1)) begin
                        n_busy[r_v]    = 1'b0;
                        n_is_solo[r_v] = 1'b0;
                        if (r_is_solo[r_v]) begin
                            n_lock = 1'b0;
                        end
                    end
                end
                if (!last_v) begin
                    n_v = r_v + 1'b1;
                end
            end
            ST_PLAY_SCAN: begin
                // First free voice wins; else track the shortest, lowest index on ties
                if (!r_busy[r_v]) begin
                    if (!r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_slot  = r_v;
                    end
                end else if ({1'b0, r_vrem[r_v]} < r_least) begin
                    n_least    = {1'b0, r_vrem[r_v]};
                    n_min_slot = r_v;
                end
                if (!last_v) begin
                    n_v = r_v + 1'b1;
                end
            end
            ST_PLAY_LOAD: begin
                n_busy[load_slot]    = 1'b1;
                n_is_solo[load_slot] = 1'b0;
                n_vaddr[load_slot]   = r_clip_start[k_idx];
                n_vrem[load_slot]    = r_clip_len[k_idx];
                n_accepted           = 1'b1;
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_out_valid                 = 1'b1;
                    n_out_data.mixed_sample     = mix_sat;
                    n_out_data.sample_valid     = (r_item.operation == OP_TICK);
                    n_out_data.request_accepted = r_accepted;
                    n_out_data.active_voices    = ACTV_W'(vcount);
                end
            end
            default: begin
            end
        endcase
    end

    // Control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_busy       <= '0;
            r_is_solo    <= '0;
            r_lock       <= 1'b0;
            r_clip_solo  <= '0;
            r_clip_count <= '0;
            r_out_valid  <= 1'b0;
            for (int c = 0; c < CLIPS; c++) begin
                r_clip_len[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_busy      <= n_busy;
            r_is_solo   <= n_is_solo;
            r_lock      <= n_lock;
            r_clip_solo <= n_clip_solo;
            r_clip_len  <= n_clip_len;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_clip_count <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in_data;
        end
        r_v          <= n_v;
        r_acc        <= n_acc;
        r_accepted   <= n_accepted;
        r_vaddr      <= n_vaddr;
        r_vrem       <= n_vrem;
        r_free_found <= n_free_found;
        r_free_slot  <= n_free_slot;
        r_min_slot   <= n_min_slot;
        r_least      <= n_least;
        r_clip_start <= n_clip_start;
        r_out_data   <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // The solo lock belongs to a playing solo voice 0
    `PVM_ASSERT_NOW(a_lock_owner, i_clk, i_rst_n, r_lock,
                    r_busy[0] && r_is_solo[0], "solo lock without solo voice 0")
    // A playing voice always has samples left
    `PVM_ASSERT_NOW(a_busy_has_samples, i_clk, i_rst_n, |r_busy,
                    (r_busy & ~rem_live) == '0, "busy voice with zero remaining")
    // An accepted transaction always starts the sequencer
    `PVM_ASSERT_NEXT(a_accept_dispatch, i_clk, i_rst_n, in_accept,
                     r_state == ST_DISPATCH, "accepted transaction not dispatched")

endmodule

// ===== rtl/pvm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the sample memory.
module pvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
